/* hw/rtl/sbdm_pkg.sv */
// ----------------------------------------------------------------------------
// sbdm_pkg
// Shared types, constants and tables for the single-bin DFT magnitude meter.
// ----------------------------------------------------------------------------
package sbdm_pkg;

    // block sizing and widths
    localparam int MAX_BLOCK    = 4096;
    localparam int SAMPLE_BITS  = 16;
    localparam int LEN_BITS     = 13;
    localparam int ACC_BITS     = 48;
    localparam int PHASE_BITS   = 32;
    localparam int MAG_BITS     = 28;
    localparam int CFG_IDX_BITS = 8;
    localparam int CFG_DATA_BITS = 32;

    // cordic rotator: 34-bit signed x, y and z give headroom at scale 2^30
    localparam int CORDIC_STEPS = 20;
    localparam int CORD_BITS    = 34;
    localparam int TW_BITS      = 16;
    localparam logic signed [CORD_BITS-1:0] CORDIC_GAIN_INV = 34'sd652032874;

    // integer square root over a 58-bit radicand, two bits per step
    localparam int RAD_BITS    = 58;
    localparam int ROOT_STEPS  = RAD_BITS / 2;
    localparam int ROOT_BITS   = ROOT_STEPS;
    localparam int REM_BITS    = 32;
    localparam int STEP_BITS   = 5;

    localparam logic [MAG_BITS-1:0] MAG_MAX = {MAG_BITS{1'b1}};

    // register map
    localparam logic [CFG_IDX_BITS-1:0] REG_BIN_PHASE_STEP = 8'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_BLOCK_LENGTH   = 8'd1;
    localparam logic [LEN_BITS-1:0]     BLOCK_LENGTH_RST   = 13'd1024;

    // controller states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ROT,
        ST_TWID,
        ST_MAC,
        ST_ADV,
        ST_SQ_A,
        ST_SQ_B,
        ST_RINIT,
        ST_ROOT,
        ST_RES
    } sbdm_state_t;

    // multiply-accumulate operand selection
    typedef enum logic [1:0] {
        MAC_RE_IC,  // re += i*c
        MAC_RE_QS,  // re += q*s
        MAC_IM_QC,  // im += q*c
        MAC_IM_IS   // im -= i*s
    } mac_sel_t;

    // controller to datapath commands
    typedef struct packed {
        logic                 capture;   // take sample, start rotator
        logic                 rot_step;
        logic                 tw_load;
        logic                 mac_en;
        mac_sel_t             mac_sel;
        logic                 advance;   // advance phase/count or close the block
        logic                 sq_en;
        logic                 sq_sel;
        logic                 root_init;
        logic                 root_step;
        logic                 res_load;
        logic [STEP_BITS-1:0] step;
    } sbdm_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic block_end;
        logic out_free;
    } sbdm_status_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [PHASE_BITS-1:0] atan_turn(input logic [STEP_BITS-1:0] idx);
        logic [PHASE_BITS-1:0] v;
        begin
            case (idx)
                5'd0:    v = 32'd536870912;
                5'd1:    v = 32'd316933405;
                5'd2:    v = 32'd167458907;
                5'd3:    v = 32'd85004756;
                5'd4:    v = 32'd42667331;
                5'd5:    v = 32'd21354465;
                5'd6:    v = 32'd10679838;
                5'd7:    v = 32'd5340245;
                5'd8:    v = 32'd2670163;
                5'd9:    v = 32'd1335087;
                5'd10:   v = 32'd667544;
                5'd11:   v = 32'd333772;
                5'd12:   v = 32'd166886;
                5'd13:   v = 32'd83443;
                5'd14:   v = 32'd41722;
                5'd15:   v = 32'd20861;
                5'd16:   v = 32'd10430;
                5'd17:   v = 32'd5215;
                5'd18:   v = 32'd2608;
                5'd19:   v = 32'd1304;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage

/* hw/rtl/single_bin_dft_magnitude_top.sv */
// ----------------------------------------------------------------------------
// single_bin_dft_magnitude_top
// Single-bin DFT magnitude meter over blocks of complex samples.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one I/Q sample per transaction; m_* carries one magnitude at
//   the end of every block. cfg_* writes bin_phase_step (index 0) and
//   block_length (index 1); other indexes are ignored. cfg_ready is always
//   high; write only while no sample is in flight.
// Sequence:
//   each accepted sample runs 20 cordic rotator steps for the twiddle, a
//   rounding step, the four products of the complex multiply on the shared
//   multiplier and a phase advance before the next sample can be taken. The
//   last sample of a block then adds the squaring of both parts, one load
//   and 29 square root iterations, then the result moves to the output
//   register once it is free.
// Reset:
//   accumulators, phase and count clear, bin_phase_step is 0 and
//   block_length is 1024; no result is pending.
// Stalls:
//   a waiting result sits in the output register while new samples are
//   accepted; only a second finished block waits for m_tready.
// ----------------------------------------------------------------------------
module single_bin_dft_magnitude_top (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream: [15:0] sample_i, [31:16] sample_q
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // master stream: [27:0] magnitude, [31:28] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import sbdm_pkg::*;

    sbdm_cmd_t            cmd;
    sbdm_status_t         status;
    logic [MAG_BITS-1:0]  magnitude;

    // sequencer
    sbdm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    // arithmetic and state
    sbdm_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tdata     (s_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_magnitude (magnitude)
    );

    // output packing and configuration handshake
    assign m_tdata   = {{(32-MAG_BITS){1'b0}}, magnitude};
    assign cfg_ready = 1'b1;

endmodule

/* hw/rtl/sbdm_ctrl.sv */
// ----------------------------------------------------------------------------
// sbdm_ctrl
// Sequencer for the bin meter: rotator steps, multiply-accumulate, block
// close, squaring and the square root iterations.
// ----------------------------------------------------------------------------
module sbdm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  sbdm_pkg::sbdm_status_t status,
    output sbdm_pkg::sbdm_cmd_t    cmd
);
    import sbdm_pkg::*;

    sbdm_state_t           state_reg, state_next;
    logic [STEP_BITS-1:0]  step_reg, step_next;

    // state and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        step_next    = step_reg;
        cmd          = '0;
        cmd.step     = step_reg;
        cmd.mac_sel  = mac_sel_t'(step_reg[1:0]);
        s_tready     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    step_next   = '0;
                    state_next  = ST_ROT;
                end
            end
            ST_ROT:
            begin
                cmd.rot_step = 1'b1;
                if (step_reg == STEP_BITS'(CORDIC_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_TWID;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_TWID:
            begin
                cmd.tw_load = 1'b1;
                step_next   = '0;
                state_next  = ST_MAC;
            end
            ST_MAC:
            begin
                cmd.mac_en = 1'b1;
                if (step_reg == STEP_BITS'(3))
                begin
                    step_next  = '0;
                    state_next = ST_ADV;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_ADV:
            begin
                cmd.advance = 1'b1;
                state_next  = status.block_end ? ST_SQ_A : ST_IDLE;
            end
            ST_SQ_A:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sq_sel = 1'b0;
                state_next = ST_SQ_B;
            end
            ST_SQ_B:
            begin
                cmd.sq_en  = 1'b1;
                cmd.sq_sel = 1'b1;
                state_next = ST_RINIT;
            end
            ST_RINIT:
            begin
                cmd.root_init = 1'b1;
                step_next     = '0;
                state_next    = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.root_step = 1'b1;
                if (step_reg == STEP_BITS'(ROOT_STEPS - 1))
                begin
                    step_next  = '0;
                    state_next = ST_RES;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_RES:
            begin
                if (status.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // only one datapath phase is commanded at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.capture, cmd.rot_step, cmd.tw_load, cmd.mac_en, cmd.advance,
                  cmd.sq_en, cmd.root_init, cmd.root_step, cmd.res_load}))
        else $error("sbdm_ctrl: overlapping datapath commands");

    // rotator runs exactly its step count before the twiddle is rounded
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.tw_load |-> $past(cmd.rot_step) && $past(step_reg) == STEP_BITS'(CORDIC_STEPS - 1))
        else $error("sbdm_ctrl: twiddle loaded before rotator finished");

    // a result is only loaded after the last root iteration
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.root_step && step_reg == STEP_BITS'(ROOT_STEPS - 1)) |=> state_reg == ST_RES)
        else $error("sbdm_ctrl: root sequence did not end in result state");

endmodule

/* hw/rtl/sbdm_datapath.sv */
// ----------------------------------------------------------------------------
// sbdm_datapath
// Configuration registers, phase/count state, cordic twiddle generator,
// shared complex multiply-accumulate, squarer, square root and result register.
// ----------------------------------------------------------------------------
module sbdm_datapath (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic [2*sbdm_pkg::SAMPLE_BITS-1:0]        s_tdata,
    input  logic                                      cfg_valid,
    input  logic [sbdm_pkg::CFG_IDX_BITS-1:0]         cfg_index,
    input  logic [sbdm_pkg::CFG_DATA_BITS-1:0]        cfg_data,
    input  sbdm_pkg::sbdm_cmd_t                       cmd,
    output sbdm_pkg::sbdm_status_t                    status,
    output logic                                      m_tvalid,
    input  logic                                      m_tready,
    output logic [sbdm_pkg::MAG_BITS-1:0]             m_magnitude
);
    import sbdm_pkg::*;

    // configuration registers
    logic [PHASE_BITS-1:0] step_cfg_reg;
    logic [LEN_BITS-1:0]   len_cfg_reg;

    // block state
    logic signed [ACC_BITS-1:0] acc_re_reg, acc_re_next;
    logic signed [ACC_BITS-1:0] acc_im_reg, acc_im_next;
    logic [PHASE_BITS-1:0]      phase_reg;
    logic [LEN_BITS-1:0]        count_reg;
    logic                       m_tvalid_reg;

    // payload registers
    logic signed [SAMPLE_BITS-1:0] xi_reg, xq_reg;
    logic                          flip_reg;
    logic signed [CORD_BITS-1:0]   cx_reg, cy_reg, cz_reg;
    logic signed [TW_BITS-1:0]     tw_c_reg, tw_s_reg;
    logic [MAG_BITS-1:0]           a_reg, b_reg;
    logic                          sat_reg;
    logic [RAD_BITS-1:0]           sum_reg;
    logic [RAD_BITS-1:0]           rad_reg;
    logic [REM_BITS-1:0]           rem_reg;
    logic [ROOT_BITS-1:0]          root_reg;
    logic [MAG_BITS-1:0]           mag_reg;

    logic [1:0]                    quad;
    logic                          flip;
    logic [PHASE_BITS-1:0]         fold_phase;
    logic signed [CORD_BITS-1:0]   dx, dy, atan_ext;
    logic signed [CORD_BITS-1:0]   rx_next, ry_next, rz_next;
    logic signed [TW_BITS-1:0]     c_q15, s_q15;
    logic signed [SAMPLE_BITS-1:0] mul_a;
    logic signed [TW_BITS-1:0]     mul_b;
    logic signed [SAMPLE_BITS+TW_BITS-1:0] prod;
    logic signed [ACC_BITS-1:0]    prod_ext;
    logic [LEN_BITS-1:0]           len_eff;
    logic [LEN_BITS-1:0]           count_inc;
    logic                          block_end;
    logic [ACC_BITS-1:0]           abs_re, abs_im;
    logic [ACC_BITS-16:0]          a_full, b_full;
    logic [MAG_BITS-1:0]           sq_op;
    logic [2*MAG_BITS-1:0]         sq_prod;
    logic [REM_BITS-1:0]           rem_sh, trial;
    logic [ROOT_BITS-1:0]          root_next;
    logic [REM_BITS-1:0]           rem_next;

    // round a scale-2^30 cordic value to saturated q1.15
    function automatic logic signed [TW_BITS-1:0] to_q15(input logic signed [CORD_BITS-1:0] v);
        logic signed [CORD_BITS-1:0]  biased;
        logic signed [CORD_BITS-16:0] r;
        logic signed [TW_BITS-1:0]    q;
        begin
            biased = v + CORD_BITS'(16384);
            r      = (CORD_BITS-15)'(biased >>> 15);
            if (r > (CORD_BITS-15)'(32767))
                q = 16'sd32767;
            else if (r < -(CORD_BITS-15)'(32767))
                q = -16'sd32767;
            else
                q = r[TW_BITS-1:0];
            return q;
        end
    endfunction

    // configuration writes, unknown indexes dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cfg_reg <= '0;
            len_cfg_reg  <= BLOCK_LENGTH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BIN_PHASE_STEP: step_cfg_reg <= cfg_data[PHASE_BITS-1:0];
                REG_BLOCK_LENGTH:   len_cfg_reg  <= cfg_data[LEN_BITS-1:0];
                default:            ;
            endcase
        end
    end

    // phase fold into the right half-plane
    assign quad       = phase_reg[PHASE_BITS-1 -: 2];
    assign flip       = (quad == 2'd1) || (quad == 2'd2);
    assign fold_phase = flip ? (phase_reg - 32'h8000_0000) : phase_reg;

    // one cordic micro-rotation
    always_comb
    begin
        dx       = cy_reg >>> cmd.step;
        dy       = cx_reg >>> cmd.step;
        atan_ext = CORD_BITS'(atan_turn(cmd.step));
        if (!cz_reg[CORD_BITS-1])
        begin
            rx_next = cx_reg - dx;
            ry_next = cy_reg + dy;
            rz_next = cz_reg - atan_ext;
        end
        else
        begin
            rx_next = cx_reg + dx;
            ry_next = cy_reg - dy;
            rz_next = cz_reg + atan_ext;
        end
    end

    assign c_q15 = to_q15(cx_reg);
    assign s_q15 = to_q15(cy_reg);

    // shared 16x16 multiplier for the complex product
    always_comb
    begin
        case (cmd.mac_sel)
            MAC_RE_IC: begin mul_a = xi_reg; mul_b = tw_c_reg; end
            MAC_RE_QS: begin mul_a = xq_reg; mul_b = tw_s_reg; end
            MAC_IM_QC: begin mul_a = xq_reg; mul_b = tw_c_reg; end
            MAC_IM_IS: begin mul_a = xi_reg; mul_b = tw_s_reg; end
            default:   begin mul_a = xi_reg; mul_b = tw_c_reg; end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = ACC_BITS'(prod);

    // block length clamp and end test
    always_comb
    begin
        if (len_cfg_reg == '0)
            len_eff = LEN_BITS'(1);
        else if (len_cfg_reg > LEN_BITS'(MAX_BLOCK))
            len_eff = LEN_BITS'(MAX_BLOCK);
        else
            len_eff = len_cfg_reg;
    end

    assign count_inc = count_reg + 1'b1;
    assign block_end = (count_inc >= len_eff);

    // accumulate with 48-bit wrap
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        case (cmd.mac_sel)
            MAC_RE_IC: acc_re_next = acc_re_reg + prod_ext;
            MAC_RE_QS: acc_re_next = acc_re_reg + prod_ext;
            MAC_IM_QC: acc_im_next = acc_im_reg + prod_ext;
            MAC_IM_IS: acc_im_next = acc_im_reg - prod_ext;
            default:   ;
        endcase
    end

    // truncated magnitudes of the accumulators
    assign abs_re = acc_re_reg[ACC_BITS-1] ? (ACC_BITS'(0) - acc_re_reg) : acc_re_reg;
    assign abs_im = acc_im_reg[ACC_BITS-1] ? (ACC_BITS'(0) - acc_im_reg) : acc_im_reg;
    assign a_full = abs_re[ACC_BITS-1:15];
    assign b_full = abs_im[ACC_BITS-1:15];

    // squarer
    assign sq_op   = cmd.sq_sel ? b_reg : a_reg;
    assign sq_prod = sq_op * sq_op;

    // one square root digit
    always_comb
    begin
        rem_sh = {rem_reg[REM_BITS-3:0], rad_reg[RAD_BITS-1 -: 2]};
        trial  = REM_BITS'({root_reg, 2'b01});
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[ROOT_BITS-2:0], 1'b0};
        end
    end

    // block state: accumulators, phase and sample count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_re_reg <= '0;
            acc_im_reg <= '0;
            phase_reg  <= '0;
            count_reg  <= '0;
        end
        else if (cmd.mac_en)
        begin
            acc_re_reg <= acc_re_next;
            acc_im_reg <= acc_im_next;
        end
        else if (cmd.advance)
        begin
            if (block_end)
            begin
                acc_re_reg <= '0;
                acc_im_reg <= '0;
                phase_reg  <= '0;
                count_reg  <= '0;
            end
            else
            begin
                phase_reg <= phase_reg + step_cfg_reg;
                count_reg <= count_inc;
            end
        end
    end

    // working registers of the sample and block pipeline
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            xi_reg   <= s_tdata[SAMPLE_BITS-1:0];
            xq_reg   <= s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
            flip_reg <= flip;
            cx_reg   <= CORDIC_GAIN_INV;
            cy_reg   <= '0;
            cz_reg   <= CORD_BITS'($signed(fold_phase));
        end
        if (cmd.rot_step)
        begin
            cx_reg <= rx_next;
            cy_reg <= ry_next;
            cz_reg <= rz_next;
        end
        if (cmd.tw_load)
        begin
            tw_c_reg <= flip_reg ? -c_q15 : c_q15;
            tw_s_reg <= flip_reg ? -s_q15 : s_q15;
        end
        if (cmd.advance && block_end)
        begin
            a_reg   <= a_full[MAG_BITS-1:0];
            b_reg   <= b_full[MAG_BITS-1:0];
            sat_reg <= (a_full > (ACC_BITS-15)'(MAG_MAX)) || (b_full > (ACC_BITS-15)'(MAG_MAX));
        end
        if (cmd.sq_en)
        begin
            sum_reg <= (cmd.sq_sel ? sum_reg : '0) + RAD_BITS'(sq_prod);
        end
        if (cmd.root_init)
        begin
            rad_reg  <= sum_reg;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[RAD_BITS-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.res_load)
        begin
            if (sat_reg || root_reg > ROOT_BITS'(MAG_MAX))
                mag_reg <= MAG_MAX;
            else
                mag_reg <= root_reg[MAG_BITS-1:0];
        end
    end

    // output register flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.res_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    assign m_tvalid         = m_tvalid_reg;
    assign m_magnitude      = mag_reg;
    assign status.block_end = block_end;
    assign status.out_free  = !m_tvalid_reg || m_tready;

    // result register is never overwritten while a result is still pending
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.res_load |-> (!m_tvalid_reg || m_tready))
        else $error("sbdm_datapath: result overwrites a pending transaction");

    // closing a block clears the running state
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && block_end) |=> (acc_re_reg == '0 && acc_im_reg == '0 &&
                                         phase_reg == '0 && count_reg == '0))
        else $error("sbdm_datapath: block state not cleared at block end");

    // the stored count stays below the largest block
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg < LEN_BITS'(MAX_BLOCK))
        else $error("sbdm_datapath: sample count out of range");

    // an overflowed block always reports the saturated magnitude
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.res_load && sat_reg) |=> mag_reg == MAG_MAX)
        else $error("sbdm_datapath: saturation lost");

endmodule
